>>> hdl/isud_pkg.sv
// shared constants and types for the interval set core
package isud_pkg;
  localparam int MAX_BOUNDARIES_DEF = 64;
  localparam int KEY_W = 32;
  localparam int INDEX_W = 5;
  localparam int ICOUNT_W = 6;

  localparam logic [1:0] CMD_UNION = 2'd0;
  localparam logic [1:0] CMD_SUBTRACT = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic signed [KEY_W-1:0] range_start;
    logic signed [KEY_W-1:0] range_end;
    logic [INDEX_W-1:0] interval_index;
  } isud_req_t;

  typedef struct packed {
    logic [ICOUNT_W-1:0] interval_count;
    logic is_empty;
    logic signed [KEY_W-1:0] interval_start;
    logic signed [KEY_W-1:0] interval_end;
    logic index_valid;
    logic overflow;
  } isud_rsp_t;
endpackage

>>> hdl/isud_req_if.sv
// request channel interface
interface isud_req_if import isud_pkg::*; ();
  logic valid;
  logic ready;
  isud_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/isud_rsp_if.sv
// result channel interface
interface isud_rsp_if import isud_pkg::*; ();
  logic valid;
  logic ready;
  isud_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/interval_set_union_difference_core.sv
// top level: interval set kept as a sorted boundary table, union/subtract/clear/read
//
//   channel | dir | handshake     | payload
//   req     | in  | valid / ready | command, range_start, range_end, interval_index
//   rsp     | out | valid / ready | interval_count, is_empty, interval_start,
//           |     |               | interval_end, index_valid, overflow
//
// one request at a time; ready is low from acceptance until the result is taken
// clear, an empty range and an out-of-range read go straight to the result; a read
// fetches two keys; union/subtract scan the stored keys, then check for overflow,
// shift the tail keys when they have to move, and write the new boundaries
// ready returns the cycle after the result is taken; key memory undefined after
// reset, only the key count is cleared; result register holds until taken
module interval_set_union_difference_core import isud_pkg::*; #(
  parameter int MAX_BOUNDARIES = MAX_BOUNDARIES_DEF
) (
  input logic clk,
  input logic rst,
  isud_req_if.sink req,
  isud_rsp_if.source rsp
);
  localparam int AW = $clog2(MAX_BOUNDARIES);
  localparam int CW = $clog2(MAX_BOUNDARIES + 1);
  localparam int SW = CW + 1;
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PLAN = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_INS = 3'd4;
  localparam logic [2:0] S_READ = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  logic [2:0] state;
  isud_req_t cur;
  logic [CW-1:0] count;
  logic [CW-1:0] below, upto;
  logic [CW-1:0] ptr;            // scan / read pointer
  logic rvalid;                  // ram data of the previous read is valid this cycle
  logic [CW-1:0] src, dst;       // tail shift pointers
  logic [CW-1:0] left;           // tail keys still to read
  logic dir_up;
  logic ins_phase;
  isud_rsp_t rsp_q;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [KEY_W-1:0] wdata, rdata;

  isud_ram #(.WIDTH(KEY_W), .DEPTH(MAX_BOUNDARIES)) u_keys (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // shared compare unit: stored key against both range ends
  logic signed [KEY_W-1:0] key_s;
  logic lt_s, le_e;
  assign key_s = rdata;
  assign lt_s = key_s < cur.range_start;
  assign le_e = key_s <= cur.range_end;

  logic adding;
  assign adding = (cur.command == CMD_UNION);

  // new boundaries at the range ends where membership changes
  logic ins_s, ins_e;
  assign ins_s = adding ? !below[0] : below[0];
  assign ins_e = adding ? !upto[0] : upto[0];

  logic [SW-1:0] m_new, total;
  logic [CW-1:0] kept_tail;
  assign m_new = SW'(below) + SW'(ins_s) + SW'(ins_e);
  assign kept_tail = count - upto;
  assign total = m_new + SW'(kept_tail);

  always_comb begin
    raddr = '0;
    we = 1'b0;
    waddr = '0;
    wdata = rdata;
    case (state)
      S_SCAN: raddr = ptr[AW-1:0];
      S_MOVE: begin
        // pipelined copy: read src now, write previous read to dst
        raddr = src[AW-1:0];
        we = rvalid;
        waddr = dst[AW-1:0];
      end
      S_INS: begin
        if (!ins_phase) begin
          we = ins_s;
          waddr = below[AW-1:0];
          wdata = cur.range_start;
        end else begin
          we = ins_e;
          waddr = below[AW-1:0] + AW'(ins_s);
          wdata = cur.range_end;
        end
      end
      S_READ: raddr = AW'({cur.interval_index, ptr[0]});
      default: ;
    endcase
  end

  logic [CW-1:0] intervals;
  assign intervals = count >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rsp.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= req.data;
            rsp_q <= '0;
            ptr <= '0;
            rvalid <= 1'b0;
            below <= '0;
            upto <= '0;
            ins_phase <= 1'b0;
            case (req.data.command)
              CMD_CLEAR: begin
                count <= '0;
                state <= S_OUT;
              end
              CMD_READ: begin
                if (CMPW'(req.data.interval_index) < CMPW'(count >> 1)) state <= S_READ;
                else state <= S_OUT;
              end
              default: begin
                if (req.data.range_start >= req.data.range_end) state <= S_OUT;
                else state <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          // count keys below the start and up to the end
          if (rvalid) begin
            if (lt_s) below <= below + 1'b1;
            if (le_e) upto <= upto + 1'b1;
          end
          if (ptr != count) begin
            ptr <= ptr + 1'b1;
            rvalid <= 1'b1;
          end else begin
            rvalid <= 1'b0;
            state <= S_PLAN;
          end
        end
        S_PLAN: begin
          if (total > SW'(MAX_BOUNDARIES)) begin
            rsp_q.overflow <= 1'b1;
            state <= S_OUT;
          end else if (kept_tail == '0 || m_new == SW'(upto)) begin
            state <= S_INS;
          end else begin
            // shift up walks the tail downward so nothing is overwritten early
            dir_up <= (m_new > SW'(upto));
            if (m_new > SW'(upto)) begin
              src <= count - 1'b1;
              dst <= total[CW-1:0] - 1'b1;
            end else begin
              src <= upto;
              dst <= m_new[CW-1:0];
            end
            left <= kept_tail;
            rvalid <= 1'b0;
            state <= S_MOVE;
          end
        end
        S_MOVE: begin
          if (rvalid) dst <= dir_up ? dst - 1'b1 : dst + 1'b1;
          if (left != '0) begin
            src <= dir_up ? src - 1'b1 : src + 1'b1;
            left <= left - 1'b1;
            rvalid <= 1'b1;
          end else begin
            rvalid <= 1'b0;
            state <= S_INS;
          end
        end
        S_INS: begin
          if (!ins_phase) begin
            ins_phase <= 1'b1;
          end else begin
            count <= total[CW-1:0];
            state <= S_OUT;
          end
        end
        S_READ: begin
          // registered read: start key arrives in the cycle after its address, end key in the cycle after that
          ptr <= ptr + 1'b1;
          if (ptr == CW'(1)) rsp_q.interval_start <= rdata;
          if (ptr == CW'(2)) begin
            rsp_q.interval_end <= rdata;
            rsp_q.index_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rsp.valid) begin
            rsp.valid <= 1'b1;
            rsp.data <= '{interval_count: ICOUNT_W'(intervals),
                          is_empty: (intervals == '0),
                          interval_start: rsp_q.interval_start,
                          interval_end: rsp_q.interval_end,
                          index_valid: rsp_q.index_valid,
                          overflow: rsp_q.overflow};
          end else if (rsp.ready) begin
            rsp.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);

`ifndef SYNTHESIS
  a_count_even: assert property (@(posedge clk) disable iff (rst) !count[0])
    else $error("odd boundary count");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BOUNDARIES)) else $error("boundary count too large");
  a_no_ready_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("accepting while result pending");
`endif
endmodule

>>> hdl/isud_ram.sv
// generic simple dual-port ram (one write port, one read port) with registered read
module isud_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> tb/interval_set_union_difference_core_tb.sv
// testbench for the interval set core: scoreboard, request and result drivers
`timescale 1ns / 100ps

module testbench;
  import isud_pkg::*;

  localparam int MAX_KEYS = MAX_BOUNDARIES_DEF;
  localparam int CYCLE_LIMIT = 1000000;

  // scoreboard: mirror of the boundary table plus queue of predicted results
  class interval_scoreboard;
    logic signed [KEY_W-1:0] keys[MAX_KEYS];
    int key_count;
    isud_rsp_t pending[$];
    int errors;

    function new();
      key_count = 0;
      errors = 0;
    endfunction

    // apply a union (adding=1) or subtract; returns overflow
    function bit apply_range(logic signed [KEY_W-1:0] s, logic signed [KEY_W-1:0] e,
                             bit adding);
      logic signed [KEY_W-1:0] merged[$];
      int below_s;
      int upto_e;
      bit left_in;
      bit right_in;
      below_s = 0;
      upto_e = 0;
      if (s >= e) return 1'b0;
      for (int k = 0; k < key_count; k++) begin
        if (keys[k] < s) below_s++;
        if (keys[k] <= e) upto_e++;
      end
      left_in = below_s[0];
      right_in = upto_e[0];
      for (int k = 0; k < below_s; k++) merged.push_back(keys[k]);
      if (adding ? !left_in : left_in) merged.push_back(s);
      if (adding ? !right_in : right_in) merged.push_back(e);
      if (merged.size() + (key_count - upto_e) > MAX_KEYS) return 1'b1;
      for (int k = upto_e; k < key_count; k++) merged.push_back(keys[k]);
      foreach (merged[k]) keys[k] = merged[k];
      key_count = merged.size();
      return 1'b0;
    endfunction

    // note an accepted request and predict its result
    function void note_request(isud_req_t r);
      isud_rsp_t x;
      int n;
      x = '0;
      case (r.command)
        CMD_UNION: x.overflow = apply_range(r.range_start, r.range_end, 1'b1);
        CMD_SUBTRACT: x.overflow = apply_range(r.range_start, r.range_end, 1'b0);
        CMD_CLEAR: key_count = 0;
        default: begin
          if (r.interval_index < key_count / 2) begin
            x.interval_start = keys[2 * r.interval_index];
            x.interval_end = keys[2 * r.interval_index + 1];
            x.index_valid = 1'b1;
          end
        end
      endcase
      n = key_count / 2;
      x.interval_count = n[ICOUNT_W-1:0];
      x.is_empty = (n == 0);
      pending.push_back(x);
    endfunction

    // check an accepted result against the oldest prediction
    function void check_result(isud_rsp_t got);
      isud_rsp_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.interval_count !== want.interval_count) begin
        $display("%0t: interval_count exp %0d got %0d", $time, want.interval_count,
                 got.interval_count);
        errors++;
      end
      if (got.is_empty !== want.is_empty) begin
        $display("%0t: is_empty exp %0d got %0d", $time, want.is_empty, got.is_empty);
        errors++;
      end
      if (got.interval_start !== want.interval_start) begin
        $display("%0t: interval_start exp %0d got %0d", $time, want.interval_start,
                 got.interval_start);
        errors++;
      end
      if (got.interval_end !== want.interval_end) begin
        $display("%0t: interval_end exp %0d got %0d", $time, want.interval_end,
                 got.interval_end);
        errors++;
      end
      if (got.index_valid !== want.index_valid) begin
        $display("%0t: index_valid exp %0d got %0d", $time, want.index_valid,
                 got.index_valid);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow exp %0d got %0d", $time, want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int cycle_count;
  bit stimulus_done;
  interval_scoreboard board;

  isud_req_if req ();
  isud_rsp_if rsp ();

  interval_set_union_difference_core i_dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: fails the run once the total cycle count exceeds CYCLE_LIMIT
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // send one request after a random gap, wait for acceptance
  // valid stays high across a zero gap, so it is dropped only before a real gap
  task automatic send_request(logic [1:0] cmd, logic signed [KEY_W-1:0] s,
                              logic signed [KEY_W-1:0] e, logic [INDEX_W-1:0] idx);
    isud_req_t r;
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r.command = cmd;
    r.range_start = s;
    r.range_end = e;
    r.interval_index = idx;
    req.valid <= 1'b1;
    req.data <= r;
    do @(posedge clk); while (!req.ready);
    board.note_request(r);
  endtask

  // random key, mostly from a narrow window so intervals overlap and merge
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  // result side: random stall per result
  initial begin
    int stall;
    rsp.ready = 1'b0;
    wait (!rst);
    forever begin
      stall = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      board.check_result(rsp.data);
    end
  end

  initial begin
    logic signed [KEY_W-1:0] a;
    logic signed [KEY_W-1:0] b;
    int drain;
    board = new();
    cycle_count = 0;
    stimulus_done = 1'b0;
    req.valid = 1'b0;
    req.data = '0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty reads, extremes, reversed and empty ranges, merges, overflow
    send_request(CMD_READ, 0, 0, 0);
    send_request(CMD_READ, 0, 0, 5'd31);
    send_request(CMD_UNION, 32'sh80000000, 32'sh7fffffff, 0);
    send_request(CMD_READ, 0, 0, 0);
    send_request(CMD_SUBTRACT, -10, 10, 0);
    send_request(CMD_READ, 0, 0, 1);
    send_request(CMD_READ, 0, 0, 2);
    send_request(CMD_UNION, 5, 5, 0);
    send_request(CMD_UNION, 7, 3, 0);
    send_request(CMD_SUBTRACT, 9, -9, 0);
    send_request(CMD_UNION, -10, 0, 0);
    send_request(CMD_UNION, 0, 10, 0);
    send_request(CMD_SUBTRACT, 32'sh80000000, 32'sh7fffffff, 0);
    send_request(CMD_CLEAR, 32'shffffffff, 32'shffffffff, 5'h1f);
    send_request(CMD_UNION, 32'sh7ffffffe, 32'sh7fffffff, 0);
    // add 33 disjoint intervals to the one stored; the table fills at 32 and the last two overflow
    for (int k = 0; k < 33; k++) send_request(CMD_UNION, 4 * k, 4 * k + 2, 0);
    send_request(CMD_SUBTRACT, 1, 2, 0);
    send_request(CMD_READ, 0, 0, 5'd31);
    send_request(CMD_READ, 0, 0, 5'd30);
    send_request(CMD_CLEAR, 0, 0, 0);

    // random mix, updates dominate; pause once until all results are back
    for (int n = 0; n < 1600; n++) begin
      if (n == 800) begin
        req.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      a = pick_key();
      b = pick_key();
      if ($urandom_range(0, 7) != 0 && a > b) begin
        a = b;
        b = pick_key();
      end
      case ($urandom_range(0, 19))
        0: send_request(CMD_CLEAR, $urandom, $urandom, INDEX_W'($urandom));
        1, 2, 3, 4: send_request(CMD_READ, $urandom, $urandom,
                                 INDEX_W'($urandom_range(0, 31)));
        5, 6, 7, 8, 9, 10: send_request(CMD_SUBTRACT, a, b, INDEX_W'($urandom));
        default: send_request(CMD_UNION, a, b, INDEX_W'($urandom));
      endcase
    end
    req.valid <= 1'b0;
    stimulus_done = 1'b1;

    drain = 0;
    while (board.pending.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (150) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

>>> interval_set_union_difference_core.f
hdl/isud_pkg.sv
hdl/isud_req_if.sv
hdl/isud_rsp_if.sv
hdl/isud_ram.sv
hdl/interval_set_union_difference_core.sv
tb/interval_set_union_difference_core_tb.sv
